@@ src/mlp_pkg.sv @@
package mlp_pkg;

  // Fixed number formats
  localparam int VALUE_BITS     = 16;
  localparam int FRAC_BITS      = VALUE_BITS - 4;
  localparam int ACC_BITS       = 40;
  localparam int INDEX_BITS     = 8;
  localparam int PROB_BITS      = 13;
  localparam int FEATURE_FIELDS = 5;
  localparam int SIG_ENTRIES    = 256;
  localparam int SIG_IDX_BITS   = 8;

  // Default network shape
  localparam int INPUTS_DEF     = 5;
  localparam int HIDDEN_ONE_DEF = 10;
  localparam int HIDDEN_TWO_DEF = 8;

  // Request action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_INFER = 1'b1;

  // Tag that travels with each operand pair through the multiply-accumulate
  typedef struct packed {
    logic valid;
    logic bias;
    logic last;
  } mac_ctrl_t;

  typedef logic [PROB_BITS-1:0] sig_table_t [SIG_ENTRIES];

  // Build the sigmoid table: e^-x stepped in Q0.32, value = round(2^44 / (2^32 + e^-x))
  function automatic sig_table_t build_sig_table();
    sig_table_t  tab;
    logic [63:0] e32;
    logic [63:0] step;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] v;
    logic [63:0] trial;
    e32  = 64'd4162825044;
    step = (e32 * e32 + 64'h8000_0000) >> 32;
    t    = e32;
    for (int j = 0; j < SIG_ENTRIES / 2; j++) begin
      d   = (64'd1 << 32) + t;
      num = (64'd1 << 44) + (d >> 1);
      v   = 64'd0;
      // Restoring quotient search, one bit per pass
      for (int b = PROB_BITS - 1; b >= 0; b--) begin
        trial = v | (64'd1 << b);
        if (trial * d <= num) begin
          v = trial;
        end
      end
      tab[SIG_ENTRIES / 2 + j]     = v[PROB_BITS-1:0];
      tab[SIG_ENTRIES / 2 - 1 - j] = PROB_BITS'(13'd4096 - v[PROB_BITS-1:0]);
      t = (t * step + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

@@ src/mlp_mac.sv @@
module mlp_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mlp_pkg::mac_ctrl_t                      in_ctrl,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   weight,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   operand,
  output logic signed [mlp_pkg::ACC_BITS-1:0]     acc,
  output mlp_pkg::mac_ctrl_t                      out_ctrl,
  output logic                                    busy
);

  localparam int PROD_BITS = 2 * mlp_pkg::VALUE_BITS;

  mlp_pkg::mac_ctrl_t                  ctrl_c_r;
  mlp_pkg::mac_ctrl_t                  ctrl_d_r;
  logic signed [mlp_pkg::ACC_BITS-1:0] prod_r;
  logic signed [mlp_pkg::ACC_BITS-1:0] prod_nxt;
  logic signed [mlp_pkg::ACC_BITS-1:0] acc_r;
  logic signed [mlp_pkg::ACC_BITS-1:0] acc_nxt;
  logic signed [PROD_BITS-1:0]         mul;

  // Multiply, or align the bias to the product's fraction
  assign mul = PROD_BITS'(weight) * PROD_BITS'(operand);

  always_comb begin
    if (in_ctrl.bias) begin
      prod_nxt = mlp_pkg::ACC_BITS'(weight) <<< mlp_pkg::FRAC_BITS;
    end else begin
      prod_nxt = mlp_pkg::ACC_BITS'(mul);
    end
  end

  // Load on bias, accumulate on weights, wrap at accumulator width
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl_c_r.valid) begin
      if (ctrl_c_r.bias) begin
        acc_nxt = prod_r;
      end else begin
        acc_nxt = acc_r + prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Advance the tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_c_r <= '0;
      ctrl_d_r <= '0;
    end else begin
      ctrl_c_r <= in_ctrl;
      ctrl_d_r <= ctrl_c_r;
    end
  end

  assign acc      = acc_r;
  assign out_ctrl = ctrl_d_r;
  assign busy     = ctrl_c_r.valid || ctrl_d_r.valid;

  // A neuron's sum opens with its bias, so a bias term is never flagged as its last
  a_bias_before_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_c_r.valid && ctrl_c_r.bias |-> !ctrl_c_r.last)
    else $error("bias term flagged as last");

  a_ctrl_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_d_r.valid |-> $past(ctrl_c_r.valid))
    else $error("accumulate tag without product");

  a_last_not_bias: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_d_r.valid && ctrl_d_r.last |-> !ctrl_d_r.bias)
    else $error("sum closed on a bias term");

endmodule

@@ src/mlp_forward_inference.sv @@
// One shared multiply-accumulate takes one bias or weight per cycle; each layer drains
// its pipeline before the next layer reads its activations. A new inference is
// accepted only once the previous one has finished; parameter writes are taken while idle.
// in_stall is high while an inference runs. Reset (rst_n low, synchronous) clears
// control and output valid; the parameter store holds nothing until written.
module mlp_forward_inference #(
  parameter int INPUTS     = mlp_pkg::INPUTS_DEF,
  parameter int HIDDEN_ONE = mlp_pkg::HIDDEN_ONE_DEF,
  parameter int HIDDEN_TWO = mlp_pkg::HIDDEN_TWO_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_action,
  input  logic [mlp_pkg::INDEX_BITS-1:0]          in_param_index,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   in_param_value,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   in_feature_0,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   in_feature_1,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   in_feature_2,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   in_feature_3,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0]   in_feature_4,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [mlp_pkg::PROB_BITS-1:0]           out_probability,
  output logic                                    out_jump
);

  localparam int VB  = mlp_pkg::VALUE_BITS;
  localparam int AB  = mlp_pkg::ACC_BITS;
  localparam int FB  = mlp_pkg::FRAC_BITS;

  // Parameter layout
  localparam int OFS_W1      = 0;
  localparam int OFS_B1      = OFS_W1 + HIDDEN_ONE * INPUTS;
  localparam int OFS_W2      = OFS_B1 + HIDDEN_ONE;
  localparam int OFS_B2      = OFS_W2 + HIDDEN_TWO * HIDDEN_ONE;
  localparam int OFS_W3      = OFS_B2 + HIDDEN_TWO;
  localparam int OFS_B3      = OFS_W3 + HIDDEN_TWO;
  localparam int PARAM_COUNT = OFS_B3 + 1;
  localparam int PW          = $clog2(PARAM_COUNT);

  localparam int MAX_TERMS   = (INPUTS > HIDDEN_ONE) ?
                               ((INPUTS > HIDDEN_TWO) ? INPUTS : HIDDEN_TWO) :
                               ((HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO);
  localparam int MAX_NEURONS = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
  localparam int TW          = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int NW          = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int H1W         = (HIDDEN_ONE > 1) ? $clog2(HIDDEN_ONE) : 1;
  localparam int H2W         = (HIDDEN_TWO > 1) ? $clog2(HIDDEN_TWO) : 1;

  localparam logic signed [VB-1:0] ACT_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [AB-1:0] SIG_LIM = {{(AB-1){1'b0}}, 1'b1} << (2 * FB + 3);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    L_ONE = 3'b001,
    L_TWO = 3'b010,
    L_OUT = 3'b100
  } layer_t;

  state_t                          state_r, state_nxt;
  layer_t                          layer_r, layer_nxt;
  logic [NW-1:0]                   neuron_r, neuron_nxt;
  logic [TW-1:0]                   term_r, term_nxt;
  logic                            bias_phase_r, bias_phase_nxt;
  logic [PW-1:0]                   w_ptr_r, w_ptr_nxt;
  logic [PW-1:0]                   b_ptr_r, b_ptr_nxt;
  logic [NW-1:0]                   wr_idx_r, wr_idx_nxt;
  logic                            out_valid_r;
  logic [mlp_pkg::PROB_BITS-1:0]   out_prob_r;
  logic                            out_jump_r;

  logic signed [VB-1:0]            wmem [PARAM_COUNT];
  logic signed [VB-1:0]            w_rd_r;
  logic signed [VB-1:0]            x_r;
  logic signed [VB-1:0]            x_nxt;
  logic signed [VB-1:0]            feat_r [mlp_pkg::FEATURE_FIELDS];
  logic signed [VB-1:0]            h1_r [HIDDEN_ONE];
  logic signed [VB-1:0]            h2_r [HIDDEN_TWO];

  mlp_pkg::mac_ctrl_t              issue;
  mlp_pkg::mac_ctrl_t              tag_b_r;
  mlp_pkg::mac_ctrl_t              tag_d;
  logic                            mac_busy;
  logic signed [AB-1:0]            acc;

  logic                            in_acc;
  logic                            wr_en;
  logic [PW-1:0]                   rd_addr;
  int                              n_terms;
  int                              n_neurons;
  logic                            term_last;
  logic                            neuron_last;
  logic                            pipe_empty;
  logic                            finish;
  logic                            act_we;
  logic signed [VB-1:0]            act;
  logic signed [AB-1:0]            acc_shr;
  logic signed [AB-1:0]            z_off;
  logic [mlp_pkg::SIG_IDX_BITS-1:0] sig_idx;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign wr_en      = in_acc && (in_action == mlp_pkg::ACT_WRITE) &&
                      (int'(in_param_index) < PARAM_COUNT);
  assign rd_addr    = bias_phase_r ? b_ptr_r : w_ptr_r;
  assign pipe_empty = !tag_b_r.valid && !mac_busy;
  assign act_we     = tag_d.valid && tag_d.last && (layer_r != L_OUT);

  // Terms and neurons of the current layer
  always_comb begin
    case (layer_r)
      L_ONE:   begin n_terms = INPUTS;     n_neurons = HIDDEN_ONE; end
      L_TWO:   begin n_terms = HIDDEN_ONE; n_neurons = HIDDEN_TWO; end
      L_OUT:   begin n_terms = HIDDEN_TWO; n_neurons = 1;          end
      default: begin n_terms = INPUTS;     n_neurons = HIDDEN_ONE; end
    endcase
  end

  assign term_last   = (term_r == TW'(n_terms - 1));
  assign neuron_last = (neuron_r == NW'(n_neurons - 1));

  // Pick the operand that pairs with the weight being read
  always_comb begin
    x_nxt = '0;
    case (layer_r)
      L_ONE: begin
        for (int f = 0; f < mlp_pkg::FEATURE_FIELDS; f++) begin
          if (f < INPUTS && term_r == TW'(f)) begin
            x_nxt = feat_r[f];
          end
        end
      end
      L_TWO:   x_nxt = h1_r[term_r[H1W-1:0]];
      L_OUT:   x_nxt = h2_r[term_r[H2W-1:0]];
      default: x_nxt = '0;
    endcase
  end

  // Sequencer: issue bias then weights per neuron, drain after each layer
  always_comb begin
    state_nxt      = state_r;
    layer_nxt      = layer_r;
    neuron_nxt     = neuron_r;
    term_nxt       = term_r;
    bias_phase_nxt = bias_phase_r;
    w_ptr_nxt      = w_ptr_r;
    b_ptr_nxt      = b_ptr_r;
    wr_idx_nxt     = act_we ? wr_idx_r + 1'b1 : wr_idx_r;
    issue          = '0;
    finish         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_action == mlp_pkg::ACT_INFER) begin
          state_nxt      = S_RUN;
          layer_nxt      = L_ONE;
          neuron_nxt     = '0;
          term_nxt       = '0;
          bias_phase_nxt = 1'b1;
          w_ptr_nxt      = PW'(OFS_W1);
          b_ptr_nxt      = PW'(OFS_B1);
          wr_idx_nxt     = '0;
        end
      end
      S_RUN: begin
        issue.valid = 1'b1;
        if (bias_phase_r) begin
          issue.bias     = 1'b1;
          bias_phase_nxt = 1'b0;
          term_nxt       = '0;
          b_ptr_nxt      = b_ptr_r + 1'b1;
        end else begin
          issue.last = term_last;
          w_ptr_nxt  = w_ptr_r + 1'b1;
          term_nxt   = term_r + 1'b1;
          if (term_last) begin
            if (neuron_last) begin
              state_nxt = S_DRAIN;
            end else begin
              neuron_nxt     = neuron_r + 1'b1;
              bias_phase_nxt = 1'b1;
            end
          end
        end
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          neuron_nxt     = '0;
          term_nxt       = '0;
          bias_phase_nxt = 1'b1;
          wr_idx_nxt     = '0;
          case (layer_r)
            L_ONE: begin
              state_nxt = S_RUN;
              layer_nxt = L_TWO;
              w_ptr_nxt = PW'(OFS_W2);
              b_ptr_nxt = PW'(OFS_B2);
            end
            L_TWO: begin
              state_nxt = S_RUN;
              layer_nxt = L_OUT;
              w_ptr_nxt = PW'(OFS_W3);
              b_ptr_nxt = PW'(OFS_B3);
            end
            default: begin
              // Hold the result until the output register is free
              if (!out_valid_r || !out_stall) begin
                finish    = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      layer_r      <= L_ONE;
      neuron_r     <= '0;
      term_r       <= '0;
      bias_phase_r <= 1'b1;
      w_ptr_r      <= '0;
      b_ptr_r      <= '0;
      wr_idx_r     <= '0;
      tag_b_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      layer_r      <= layer_nxt;
      neuron_r     <= neuron_nxt;
      term_r       <= term_nxt;
      bias_phase_r <= bias_phase_nxt;
      w_ptr_r      <= w_ptr_nxt;
      b_ptr_r      <= b_ptr_nxt;
      wr_idx_r     <= wr_idx_nxt;
      tag_b_r      <= issue;
    end
  end

  // Parameter store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[PW'(in_param_index)] <= in_param_value;
    end
    w_rd_r <= wmem[rd_addr];
  end

  // Latch features and the operand beside the weight read
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (in_acc && in_action == mlp_pkg::ACT_INFER) begin
      feat_r[0] <= in_feature_0;
      feat_r[1] <= in_feature_1;
      feat_r[2] <= in_feature_2;
      feat_r[3] <= in_feature_3;
      feat_r[4] <= in_feature_4;
    end
  end

  mlp_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctrl  (tag_b_r),
    .weight   (w_rd_r),
    .operand  (x_r),
    .acc      (acc),
    .out_ctrl (tag_d),
    .busy     (mac_busy)
  );

  // ReLU with saturation to the positive word range
  always_comb begin
    acc_shr = acc >>> FB;
    if (acc[AB-1] || acc == '0) begin
      act = '0;
    end else if (|acc_shr[AB-1:VB-1]) begin
      act = ACT_MAX;
    end else begin
      act = acc_shr[VB-1:0];
    end
  end

  // Store finished hidden activations
  always_ff @(posedge clk) begin
    if (act_we) begin
      if (layer_r == L_ONE) begin
        h1_r[wr_idx_r[H1W-1:0]] <= act;
      end else begin
        h2_r[wr_idx_r[H2W-1:0]] <= act;
      end
    end
  end

  // Sigmoid bin from the output sum clamped to -8..8
  always_comb begin
    z_off = acc + SIG_LIM;
    if (acc < -SIG_LIM) begin
      sig_idx = '0;
    end else if (acc >= SIG_LIM) begin
      sig_idx = '1;
    end else begin
      sig_idx = z_off[2*FB+3:2*FB-4];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_prob_r <= mlp_pkg::SIG_TABLE[sig_idx];
      out_jump_r <= !acc[AB-1] && (acc != '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_jump        = out_jump_r;

  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DRAIN))
    else $error("result raised outside final drain");

  a_issue_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    tag_b_r.valid |-> $past(state_r == S_RUN))
    else $error("operand issued outside run");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && state_nxt != S_DRAIN) |-> (!tag_b_r.valid && !mac_busy))
    else $error("layer left before pipeline drained");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (int'(rd_addr) < PARAM_COUNT))
    else $error("parameter read beyond store");

endmodule
